// File: rtl/huffman_code_bit_packer_unit_defines.svh
// ----------------------------------------------------------------------------
// Huffman code bit packer assertion macros
// Shared property forms for the checks attached to the packer.
// ----------------------------------------------------------------------------
`ifndef HUFFMAN_CODE_BIT_PACKER_UNIT_DEFINES_SVH
`define HUFFMAN_CODE_BIT_PACKER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HCBP_ASSERT_NOW(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("hcbp: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define HCBP_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("hcbp: next-cycle check failed");

`endif

// File: rtl/hcbp_pkg.sv
// ----------------------------------------------------------------------------
// Huffman code bit packer package
// Shared constants, operation codes, codebook entry type and result type.
// ----------------------------------------------------------------------------
`default_nettype none

package hcbp_pkg;

  localparam int MAX_CODE_LEN = 32;
  localparam int SYMBOLS      = 256;
  localparam int SYM_W        = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
  localparam int CODE_W       = 32;
  localparam int LEN_W        = 6;
  localparam int BYTE_W       = 8;
  localparam int LEN_LIMIT    = (MAX_CODE_LEN > CODE_W) ? CODE_W : MAX_CODE_LEN;
  localparam int ACC_W        = CODE_W + BYTE_W;
  localparam int IN_DATA_W    = 48;
  localparam int IN_USER_W    = 2;
  localparam int OUT_DATA_W   = 8;
  localparam int OUT_USER_W   = 2;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_ENCODE = 2'd1,
    OP_FLUSH  = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [CODE_W-1:0] code;
  } entry_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              byte_valid;
    logic              error;
    logic              last;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/huffman_code_bit_packer_unit.sv
// ----------------------------------------------------------------------------
// Huffman code bit packer
// Input items on s_axis carry the operation in tuser (0 load entry, 1 encode,
// 2 flush, 3 no operation) and symbol, code length and code bits in tdata.
// Results leave on m_axis: the packed byte in tdata, byte_valid and error in
// tuser, and tlast on the last result of each input item.
// The codebook sits in one 256-entry memory with a registered read port; a
// load writes it at the accept edge, so an encode of the same symbol in the
// next cycle already sees the new entry.
// The first result of an item is registered in the working stage and then in
// the output register. One item is taken per cycle while nothing stalls; an
// encode that completes k bytes keeps the input stalled while the bytes leave
// through the output register, one per cycle while the receiver is ready.
// Reset clears the per-entry valid bits (all lengths read as zero), the
// pending byte and both channels at once; no clearing pass is needed.
// When the receiver stalls, the output register holds its result and the
// input stops being ready once the working stage has a result to deliver.
// ----------------------------------------------------------------------------
`default_nettype none

module huffman_code_bit_packer_unit (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // symbol [7:0], code_length [13:8], code_bits [45:14], zero [47:46]
  input  wire logic [hcbp_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // op [1:0]
  input  wire logic [hcbp_pkg::IN_USER_W-1:0]   s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // out_byte [7:0]
  output logic [hcbp_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
  // byte_valid [0], error [1]
  output logic [hcbp_pkg::OUT_USER_W-1:0]       m_axis_tuser,
  output logic                                  m_axis_tlast
);

  import hcbp_pkg::*;

  op_t               in_op;
  logic [7:0]        in_sym;
  logic [LEN_W-1:0]  in_len;
  logic [CODE_W-1:0] in_code;
  logic [SYM_W-1:0]  in_idx;
  logic              in_sym_ok;
  logic              in_bad;
  logic              s_accept;

  entry_t            mem [SYMBOLS];
  logic [SYMBOLS-1:0] vld;
  entry_t            rd_ent;

  logic              s1_valid;
  op_t               s1_op;
  logic              s1_err;
  logic              s1_hit;
  logic [1:0]        idx;

  logic [BYTE_W-1:0] pbyte;
  logic [3:0]        pbits;

  logic [LEN_W-1:0]  enc_len;
  logic [CODE_W-1:0] code_m;
  logic [ACC_W-1:0]  acc;
  logic [LEN_W-1:0]  total;
  logic [2:0]        n_bytes;
  logic [3:0]        rem_bits;
  logic              enc_last;

  logic              out_ok;
  logic              want;
  logic              emit;
  logic              done;
  result_t           res;

  assign in_op     = op_t'(s_axis_tuser);
  assign in_sym    = s_axis_tdata[7:0];
  assign in_len    = s_axis_tdata[13:8];
  assign in_code   = s_axis_tdata[45:14];
  assign in_idx    = in_sym[SYM_W-1:0];
  assign in_sym_ok = 9'(in_sym) < 9'(SYMBOLS);
  assign in_bad    = !in_sym_ok || (in_len > LEN_W'(LEN_LIMIT));
  assign s_accept  = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (s_accept && in_op == OP_LOAD && !in_bad) begin
      mem[in_idx] <= '{len: in_len, code: in_code};
    end
    if (s_accept) begin
      rd_ent <= mem[in_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (s_accept && in_op == OP_LOAD && !in_bad) begin
      vld[in_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      s1_op  <= in_op;
      s1_err <= in_bad;
      s1_hit <= in_sym_ok && vld[in_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_accept) begin
      s1_valid <= 1'b1;
    end else if (done) begin
      s1_valid <= 1'b0;
    end
  end

  assign s_axis_tready = !s1_valid || done;

  always_comb begin
    enc_len  = s1_hit ? rd_ent.len : '0;
    code_m   = rd_ent.code & ~({CODE_W{1'b1}} << enc_len);
    acc      = ACC_W'(pbyte) | (ACC_W'(code_m) << pbits);
    total    = LEN_W'(pbits) + enc_len;
    n_bytes  = (enc_len == '0) ? 3'd0 : 3'((total - LEN_W'(1)) >> 3);
    rem_bits = 4'(total - (LEN_W'(n_bytes) << 3));
    enc_last = 3'(idx) == (n_bytes - 3'd1);
  end

  assign out_ok = !m_axis_tvalid || m_axis_tready;

  always_comb begin
    want = 1'b0;
    done = 1'b0;
    res  = '0;
    case (s1_op)
      OP_LOAD: begin
        want      = 1'b1;
        res.error = s1_err;
        res.last  = 1'b1;
        done      = s1_valid && out_ok;
      end
      OP_ENCODE: begin
        want           = n_bytes != 3'd0;
        res.out_byte   = acc[8*idx +: 8];
        res.byte_valid = 1'b1;
        res.last       = enc_last;
        done           = s1_valid && (!want || (out_ok && enc_last));
      end
      OP_FLUSH: begin
        want           = pbits != 4'd0;
        res.out_byte   = pbyte;
        res.byte_valid = 1'b1;
        res.last       = 1'b1;
        done           = s1_valid && (!want || out_ok);
      end
      default: begin
        done = s1_valid;
      end
    endcase
    emit = s1_valid && want && out_ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (done) begin
      idx <= '0;
    end else if (emit && s1_op == OP_ENCODE) begin
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pbyte <= '0;
      pbits <= '0;
    end else if (done && s1_op == OP_ENCODE && enc_len != '0) begin
      pbyte <= acc[8*n_bytes +: 8];
      pbits <= rem_bits;
    end else if (done && s1_op == OP_FLUSH) begin
      pbyte <= '0;
      pbits <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_axis_tdata <= res.out_byte;
      m_axis_tuser <= {res.error, res.byte_valid};
      m_axis_tlast <= res.last;
    end
  end

endmodule

`default_nettype wire

// File: rtl/hcbp_checker.sv
// ----------------------------------------------------------------------------
// Huffman code bit packer checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "huffman_code_bit_packer_unit_defines.svh"

module hcbp_checker (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             s_axis_tvalid,
  input wire logic                             s_axis_tready,
  input wire logic [hcbp_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  input wire logic [hcbp_pkg::IN_USER_W-1:0]   s_axis_tuser,
  input wire logic                             m_axis_tvalid,
  input wire logic                             m_axis_tready,
  input wire logic [hcbp_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input wire logic [hcbp_pkg::OUT_USER_W-1:0]  m_axis_tuser,
  input wire logic                             m_axis_tlast
);

  import hcbp_pkg::*;

  logic in_load;
  logic in_refused;
  logic load_prev;
  logic refused_prev;

  assign in_load = s_axis_tvalid && s_axis_tready && (op_t'(s_axis_tuser) == OP_LOAD);
  assign in_refused = s_axis_tdata[13:8] > LEN_W'(LEN_LIMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      load_prev    <= 1'b0;
      refused_prev <= 1'b0;
    end else begin
      load_prev    <= in_load;
      refused_prev <= in_refused;
    end
  end

  `HCBP_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))

  `HCBP_ASSERT_NOW(a_byte_no_error, clk, rst, m_axis_tvalid && m_axis_tuser[0],
    !m_axis_tuser[1])

  `HCBP_ASSERT_NOW(a_status_form, clk, rst, m_axis_tvalid && !m_axis_tuser[0],
    m_axis_tdata == '0 && m_axis_tlast)

  // A load whose status can leave at once shows up on the next cycle with
  // the error flag set exactly when its length was over the limit.
  `HCBP_ASSERT_NEXT(a_load_status, clk, rst, load_prev && (!m_axis_tvalid || m_axis_tready),
    m_axis_tvalid && !m_axis_tuser[0] && m_axis_tlast &&
      (m_axis_tuser[1] == $past(refused_prev)))

endmodule

bind huffman_code_bit_packer_unit hcbp_checker u_hcbp_checker (.*);

`default_nettype wire

// File: verif/tb_huffman_code_bit_packer_unit.sv
// ----------------------------------------------------------------------------
// Huffman code bit packer testbench
// Drives codebook loads, symbol encodes and flushes into the packer with
// random gaps on both sides. A local shadow of the codebook and of the
// partly filled byte predicts every result, which is then compared against
// the output stream in arrival order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_huffman_code_bit_packer_unit;
  import hcbp_pkg::*;

  localparam int RANDOM_ITEMS = 450;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int CALM_FROM    = 300;
  localparam int CALM_TO      = 700;
  localparam int SETTLE       = 16;

  typedef struct packed {
    op_t               op;
    logic [SYM_W-1:0]  symbol;
    logic [LEN_W-1:0]  code_length;
    logic [CODE_W-1:0] code_bits;
  } packer_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;
  logic [IN_USER_W-1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [OUT_USER_W-1:0] m_axis_tuser;
  logic m_axis_tlast;

  packer_item_t symbol_stream[$];
  result_t      awaited_results[$];
  packer_item_t on_bus;
  result_t      head;
  logic         s_taken = 1'b0;
  logic         calm;
  int           cycles = 0;
  int           mismatches = 0;
  int           loads_seen = 0;
  int           refusals_seen = 0;
  int           encodes_seen = 0;
  int           flushes_seen = 0;
  int           results_checked = 0;

  logic [LEN_W-1:0]  shadow_len [SYMBOLS];
  logic [CODE_W-1:0] shadow_code [SYMBOLS];
  logic [BYTE_W-1:0] fill_byte = '0;
  int                fill_bits = 0;

  huffman_code_bit_packer_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #6 clk = ~clk;

  assign calm = (cycles >= CALM_FROM) && (cycles < CALM_TO);

  task automatic queue_item(input op_t op, input logic [SYM_W-1:0] sym,
                            input logic [LEN_W-1:0] len, input logic [CODE_W-1:0] bits);
    packer_item_t it;
    it.op = op;
    it.symbol = sym;
    it.code_length = len;
    it.code_bits = bits;
    symbol_stream.push_back(it);
  endtask

  function automatic logic [LEN_W-1:0] pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return LEN_W'($urandom_range(1, 8));
    if (r < 80) return LEN_W'($urandom_range(9, 16));
    if (r < 93) return LEN_W'($urandom_range(17, 32));
    if (r < 96) return '0;
    return LEN_W'($urandom_range(33, 63));
  endfunction

  // Applies one item to the shadow codebook and byte and queues the results it
  // releases; an encode appends its code bits, a full byte only leaves on the next bit.
  task automatic pack_item(input packer_item_t it);
    result_t batch [0:7];
    result_t r;
    int n;
    int l;
    logic refused;
    n = 0;
    case (it.op)
      OP_LOAD: begin
        refused = (int'(it.symbol) >= SYMBOLS) || (int'(it.code_length) > LEN_LIMIT);
        if (!refused) begin
          shadow_len[it.symbol] = it.code_length;
          shadow_code[it.symbol] = it.code_bits;
        end
        r = '0;
        r.error = refused;
        batch[0] = r;
        n = 1;
      end
      OP_ENCODE: begin
        l = (int'(it.symbol) < SYMBOLS) ? int'(shadow_len[it.symbol]) : 0;
        if (l > CODE_W) l = CODE_W;
        for (int i = 0; i < l; i++) begin
          if (fill_bits >= BYTE_W) begin
            r = '0;
            r.out_byte = fill_byte;
            r.byte_valid = 1'b1;
            batch[n] = r;
            n++;
            fill_byte = '0;
            fill_bits = 0;
          end
          if (shadow_code[it.symbol][i]) fill_byte[fill_bits] = 1'b1;
          fill_bits++;
        end
      end
      OP_FLUSH: begin
        if (fill_bits != 0) begin
          r = '0;
          r.out_byte = fill_byte;
          r.byte_valid = 1'b1;
          batch[0] = r;
          n = 1;
          fill_byte = '0;
          fill_bits = 0;
        end
      end
      default: ;
    endcase
    if (n > 0) batch[n-1].last = 1'b1;
    for (int k = 0; k < n; k++) awaited_results.push_back(batch[k]);
  endtask

  always @(negedge clk) begin
    if (!rst && (!s_axis_tvalid || s_taken)) begin
      if (symbol_stream.size() > 0 && (calm || $urandom_range(0, 99) >= 16)) begin
        on_bus = symbol_stream.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {2'b00, on_bus.code_bits, on_bus.code_length, on_bus.symbol};
        s_axis_tuser <= on_bus.op;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    m_axis_tready <= !rst && (calm || $urandom_range(0, 99) >= 16);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    s_taken <= s_axis_tvalid && s_axis_tready;
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      case (on_bus.op)
        OP_LOAD: begin
          loads_seen++;
          if (int'(on_bus.code_length) > LEN_LIMIT) refusals_seen++;
        end
        OP_ENCODE: encodes_seen++;
        OP_FLUSH: flushes_seen++;
        default: ;
      endcase
      pack_item(on_bus);
    end
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual byte %02h user %b last %b",
                 $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
        mismatches++;
      end else begin
        head = awaited_results.pop_front();
        results_checked++;
        if (m_axis_tdata !== head.out_byte) begin
          $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                   $time, head.out_byte, m_axis_tdata);
          mismatches++;
        end
        if (m_axis_tuser[0] !== head.byte_valid) begin
          $display("%0t: byte_valid mismatch: expected %b, actual %b",
                   $time, head.byte_valid, m_axis_tuser[0]);
          mismatches++;
        end
        if (m_axis_tuser[1] !== head.error) begin
          $display("%0t: error mismatch: expected %b, actual %b",
                   $time, head.error, m_axis_tuser[1]);
          mismatches++;
        end
        if (m_axis_tlast !== head.last) begin
          $display("%0t: last mismatch: expected %b, actual %b",
                   $time, head.last, m_axis_tlast);
          mismatches++;
        end
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Run stopped at the cycle limit with %0d results outstanding.",
             awaited_results.size());
    $display("tb_huffman_code_bit_packer_unit failed");
    $finish;
  end

  initial begin
    packer_item_t noise;
    logic [SYM_W-1:0] live_syms[$];
    logic [SYM_W-1:0] sym;
    logic [LEN_W-1:0] len;
    int made;
    int burst;

    for (int s = 0; s < SYMBOLS; s++) begin
      shadow_len[s] = '0;
      shadow_code[s] = '0;
    end

    // Directed opening: unknown symbols, empty flush, the length limit,
    // a held full byte, and the longest code on top of one pending bit.
    queue_item(OP_ENCODE, 8'h00, 6'd0, 32'h0);
    queue_item(OP_FLUSH, 8'h00, 6'd0, 32'h0);
    queue_item(OP_NOP, 8'hFF, 6'h3F, 32'hFFFF_FFFF);
    queue_item(OP_LOAD, 8'h00, 6'd1, 32'h0000_0001);
    queue_item(OP_LOAD, 8'hFF, 6'd32, 32'hFFFF_FFFF);
    queue_item(OP_LOAD, 8'h5A, 6'd33, 32'h1234_5678);
    queue_item(OP_LOAD, 8'hA5, 6'd63, 32'h0);
    queue_item(OP_LOAD, 8'h11, 6'd8, 32'h0000_00A5);
    queue_item(OP_LOAD, 8'h22, 6'd0, 32'hDEAD_BEEF);
    queue_item(OP_ENCODE, 8'h00, 6'd0, 32'h0);
    queue_item(OP_FLUSH, 8'h00, 6'd0, 32'h0);
    queue_item(OP_ENCODE, 8'h11, 6'd0, 32'h0);
    queue_item(OP_ENCODE, 8'h00, 6'd0, 32'h0);
    queue_item(OP_FLUSH, 8'h00, 6'd0, 32'h0);
    queue_item(OP_ENCODE, 8'h11, 6'd0, 32'h0);
    queue_item(OP_FLUSH, 8'h00, 6'd0, 32'h0);
    queue_item(OP_ENCODE, 8'h00, 6'd0, 32'h0);
    queue_item(OP_ENCODE, 8'hFF, 6'd0, 32'h0);
    queue_item(OP_ENCODE, 8'h22, 6'd0, 32'h0);
    queue_item(OP_ENCODE, 8'h5A, 6'd0, 32'h0);
    queue_item(OP_ENCODE, 8'hFF, 6'd0, 32'h0);
    queue_item(OP_FLUSH, 8'h00, 6'd0, 32'h0);
    queue_item(OP_LOAD, 8'h80, 6'd32, 32'h0);
    queue_item(OP_ENCODE, 8'h80, 6'd0, 32'h0);
    queue_item(OP_ENCODE, 8'h80, 6'd0, 32'h0);
    queue_item(OP_FLUSH, 8'hFF, 6'h3F, 32'hFFFF_FFFF);
    live_syms.push_back(8'h00);
    live_syms.push_back(8'hFF);
    live_syms.push_back(8'h11);

    // Mostly well-formed bursts: a few codebook loads, then encodes of
    // known symbols with occasional flushes, mixed with random noise.
    made = 0;
    while (made < RANDOM_ITEMS) begin
      if ($urandom_range(0, 99) < 80) begin
        burst = $urandom_range(1, 4);
        for (int k = 0; k < burst; k++) begin
          sym = SYM_W'($urandom_range(0, SYMBOLS - 1));
          len = pick_length();
          queue_item(OP_LOAD, sym, len, $urandom());
          if (int'(len) <= LEN_LIMIT && len != '0) live_syms.push_back(sym);
          made++;
        end
        burst = $urandom_range(4, 12);
        for (int k = 0; k < burst; k++) begin
          if ($urandom_range(0, 9) != 0)
            sym = live_syms[$urandom_range(0, live_syms.size() - 1)];
          else
            sym = SYM_W'($urandom_range(0, SYMBOLS - 1));
          if ($urandom_range(0, 7) == 0)
            queue_item(OP_FLUSH, sym, LEN_W'($urandom_range(0, 63)), $urandom());
          else
            queue_item(OP_ENCODE, sym, LEN_W'($urandom_range(0, 63)), $urandom());
          made++;
        end
        if ($urandom_range(0, 1) == 1) begin
          queue_item(OP_FLUSH, SYM_W'($urandom_range(0, SYMBOLS - 1)), '0, $urandom());
          made++;
        end
      end else begin
        burst = $urandom_range(1, 4);
        for (int k = 0; k < burst; k++) begin
          noise.op = op_t'($urandom_range(0, 3));
          noise.symbol = SYM_W'($urandom_range(0, SYMBOLS - 1));
          noise.code_length = LEN_W'($urandom_range(0, 63));
          noise.code_bits = $urandom();
          symbol_stream.push_back(noise);
          if (noise.op == OP_LOAD && int'(noise.code_length) <= LEN_LIMIT &&
              noise.code_length != '0)
            live_syms.push_back(noise.symbol);
          if (noise.op != OP_NOP) made++;
        end
      end
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (symbol_stream.size() != 0 || s_axis_tvalid) @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("Covered %0d loads (%0d over the length limit), %0d encodes, %0d flushes.",
             loads_seen, refusals_seen, encodes_seen, flushes_seen);
    $display("Checked %0d results with %0d mismatches.", results_checked, mismatches);
    if (mismatches == 0) begin
      $display("tb_huffman_code_bit_packer_unit passed");
    end else begin
      $display("tb_huffman_code_bit_packer_unit failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: huffman_code_bit_packer_unit.f
+incdir+rtl
rtl/hcbp_pkg.sv
rtl/huffman_code_bit_packer_unit.sv
rtl/hcbp_checker.sv
verif/tb_huffman_code_bit_packer_unit.sv
